// File: design/mhlt_pkg.sv
// Shared types and constants for the mail header line tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package mhlt_pkg;

  // Largest header block in bytes; a kept byte at this offset overflows.
  localparam int MAX_HEADER_BYTES = 4096;
  // Offset of a kept byte, and the position counter that can also hold the limit.
  localparam int SPAN_W = $clog2(MAX_HEADER_BYTES);
  localparam int POS_W  = SPAN_W + 1;

  // Result field widths.
  localparam int KIND_W  = 3;
  localparam int START_W = 12;
  localparam int LEN_W   = 13;
  localparam int DATA_W  = 8;
  localparam int TDATA_W = 56;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_START    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PAIR     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NAMELESS = 3'd2;
  localparam logic [KIND_W-1:0] KIND_END      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TRUNC    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_OVERFLOW = 3'd5;

  // Byte codes of interest.
  localparam logic [DATA_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [DATA_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [DATA_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [DATA_W-1:0] CHAR_SP    = 8'h20;
  localparam logic [DATA_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [DATA_W-1:0] CHAR_VT    = 8'h0B;
  localparam logic [DATA_W-1:0] CHAR_FF    = 8'h0C;

  // Token queue between the classifier and the line tracker.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // One classified input beat.
  typedef struct packed {
    logic stream_end;
    logic is_lf;
    logic is_cr;
    logic is_colon;
    logic is_space;
  } token_t;

  // Head of the token queue as seen by the line tracker.
  typedef struct packed {
    logic   valid;
    token_t tok;
  } queue_head_t;

endpackage

`default_nettype wire

// File: design/mail_header_line_tokenizer_unit.sv
// Top level of the mail header line tokenizer.
//
// Input stream: one header byte per beat in s_tdata; s_tlast marks that the
// source ran out before the header end (the byte is then ignored and a
// truncated result follows). Output stream: at most one result per input
// beat, with the result kind in m_tuser and the span offsets and lengths in
// m_tdata. Results come out in input order.
// Throughput is one byte per cycle: a classifier feeds a four-entry token
// queue, and a line tracker takes one token per cycle whenever its result
// register is empty or being drained. Each byte is registered in the token
// queue, and its result in the result register.
// When the receiver stalls, the result is held and the tracker stops; the
// queue absorbs up to four more bytes before s_tready drops.
// A synchronous reset empties the queue and the result register and re-arms
// the tracker (leading line breaks skipped, next kept byte at offset zero).
// The tracker re-arms by itself after end of headers, truncation or an
// offset overflow.
`timescale 1ns / 1ps
`default_nettype none

module mail_header_line_tokenizer_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [mhlt_pkg::DATA_W-1:0]   s_tdata,  // [7:0] data_byte
  input  wire logic                          s_tlast,  // stream_end
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [mhlt_pkg::TDATA_W-1:0]       m_tdata,  // [11:0] name_start, [24:12] name_length,
                                                       // [36:25] value_start,
                                                       // [49:37] value_length, rest zero
  output logic [mhlt_pkg::KIND_W-1:0]        m_tuser   // [2:0] kind
);

  mhlt_pkg::token_t                  tok;
  mhlt_pkg::queue_head_t             head;
  logic                              full;
  logic                              pop;
  logic [mhlt_pkg::START_W-1:0]      name_start;
  logic [mhlt_pkg::LEN_W-1:0]        name_length;
  logic [mhlt_pkg::START_W-1:0]      value_start;
  logic [mhlt_pkg::LEN_W-1:0]        value_length;

  assign s_tready = !full;

  // Byte classifier.
  mhlt_front u_front (
    .data_byte  (s_tdata),
    .stream_end (s_tlast),
    .tok        (tok)
  );

  // Token queue.
  mhlt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (s_tvalid),
    .push_tok (tok),
    .full     (full),
    .pop      (pop),
    .head     (head)
  );

  // Line tracker and result register.
  mhlt_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .pop              (pop),
    .res_valid        (m_tvalid),
    .res_ready        (m_tready),
    .res_kind         (m_tuser),
    .res_name_start   (name_start),
    .res_name_length  (name_length),
    .res_value_start  (value_start),
    .res_value_length (value_length)
  );

  // Pack the result spans, lowest field first.
  assign m_tdata = {6'd0, value_length, value_start, name_length, name_start};

  // The tracker never consumes a token while a result is stuck at the output.
  assert property (@(posedge clk) disable iff (rst) (m_tvalid && !m_tready) |-> !pop)
    else $error("token taken while result stalled");

  // A token is only consumed when the queue holds one.
  assert property (@(posedge clk) disable iff (rst) pop |-> head.valid)
    else $error("pop from empty token queue");

  // Block-level results carry no spans.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == mhlt_pkg::KIND_END || m_tuser == mhlt_pkg::KIND_TRUNC ||
                  m_tuser == mhlt_pkg::KIND_OVERFLOW)) |-> (m_tdata == '0))
    else $error("nonzero span on end, truncated or overflow result");

  // A stall holds off a new result: the valid flag does not drop without a take.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result lost during stall");

endmodule

`default_nettype wire

// File: design/mhlt_front.sv
// Front end: classifies each incoming byte into a compact token.
`timescale 1ns / 1ps
`default_nettype none

module mhlt_front (
  input  wire logic [mhlt_pkg::DATA_W-1:0] data_byte,
  input  wire logic                        stream_end,
  output mhlt_pkg::token_t                 tok
);

  // Byte classes used by the line tracker; the byte itself is not needed later.
  always_comb begin
    tok.stream_end = stream_end;
    tok.is_lf      = (data_byte == mhlt_pkg::CHAR_LF);
    tok.is_cr      = (data_byte == mhlt_pkg::CHAR_CR);
    tok.is_colon   = (data_byte == mhlt_pkg::CHAR_COLON);
    tok.is_space   = (data_byte == mhlt_pkg::CHAR_SP) || (data_byte == mhlt_pkg::CHAR_TAB) ||
                     (data_byte == mhlt_pkg::CHAR_CR) || (data_byte == mhlt_pkg::CHAR_LF) ||
                     (data_byte == mhlt_pkg::CHAR_VT) || (data_byte == mhlt_pkg::CHAR_FF);
  end

endmodule

`default_nettype wire

// File: design/mhlt_queue.sv
// Small token queue that decouples the classifier from the line tracker.
`timescale 1ns / 1ps
`default_nettype none

module mhlt_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire mhlt_pkg::token_t push_tok,
  output logic                  full,
  input  wire logic             pop,
  output mhlt_pkg::queue_head_t head
);

  mhlt_pkg::token_t                entries [mhlt_pkg::QUEUE_DEPTH];
  logic [mhlt_pkg::QPTR_W-1:0]     wr_ptr;
  logic [mhlt_pkg::QPTR_W-1:0]     rd_ptr;
  logic [mhlt_pkg::QCNT_W-1:0]     count;
  logic                            do_push;
  logic                            do_pop;

  assign full       = (count == mhlt_pkg::QCNT_W'(mhlt_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.tok   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_tok;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/mhlt_back.sv
// Back end: tracks lines and spans from tokens and holds the result register.
`timescale 1ns / 1ps
`default_nettype none

module mhlt_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire mhlt_pkg::queue_head_t        head,
  output logic                              pop,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output logic [mhlt_pkg::KIND_W-1:0]       res_kind,
  output logic [mhlt_pkg::START_W-1:0]      res_name_start,
  output logic [mhlt_pkg::LEN_W-1:0]        res_name_length,
  output logic [mhlt_pkg::START_W-1:0]      res_value_start,
  output logic [mhlt_pkg::LEN_W-1:0]        res_value_length
);

  // Line tracking state.
  logic [mhlt_pkg::POS_W-1:0]  byte_position, byte_position_next;
  logic [1:0]                  newline_run, newline_run_next;
  logic                        skipping_leading, skipping_leading_next;
  logic                        on_first_line, on_first_line_next;
  logic                        colon_seen, colon_seen_next;
  logic [mhlt_pkg::SPAN_W-1:0] name_first, name_first_next;
  logic [mhlt_pkg::SPAN_W-1:0] name_last, name_last_next;
  logic                        name_nonempty, name_nonempty_next;
  logic [mhlt_pkg::SPAN_W-1:0] value_first, value_first_next;
  logic [mhlt_pkg::SPAN_W-1:0] value_last, value_last_next;
  logic                        value_nonempty, value_nonempty_next;

  // Result being formed this cycle.
  logic                         emit;
  logic [mhlt_pkg::KIND_W-1:0]  emit_kind;
  logic                         emit_has_name;
  logic                         emit_has_value;
  logic [mhlt_pkg::SPAN_W-1:0]  emit_vf;
  logic [mhlt_pkg::SPAN_W-1:0]  emit_vl;
  logic [1:0]                   run_inc;
  logic [mhlt_pkg::SPAN_W-1:0]  off;
  mhlt_pkg::token_t             tok;

  // A token is taken whenever the result register is free or being drained.
  assign pop     = head.valid && (!res_valid || res_ready);
  assign tok     = head.tok;
  assign run_inc = newline_run + 2'd1;
  assign off     = byte_position[mhlt_pkg::SPAN_W-1:0];

  // Next state for one token.
  always_comb begin
    byte_position_next    = byte_position;
    newline_run_next      = newline_run;
    skipping_leading_next = skipping_leading;
    on_first_line_next    = on_first_line;
    colon_seen_next       = colon_seen;
    name_first_next       = name_first;
    name_last_next        = name_last;
    name_nonempty_next    = name_nonempty;
    value_first_next      = value_first;
    value_last_next       = value_last;
    value_nonempty_next   = value_nonempty;
    emit                  = 1'b0;
    emit_kind             = mhlt_pkg::KIND_END;
    emit_has_name         = 1'b0;
    emit_has_value        = 1'b0;
    emit_vf               = value_first;
    emit_vl               = value_last;

    if (pop) begin
      if (tok.stream_end) begin
        emit      = 1'b1;
        emit_kind = mhlt_pkg::KIND_TRUNC;
      end else if (skipping_leading && (tok.is_cr || tok.is_lf)) begin
        // Leading line breaks are dropped without taking an offset.
      end else if (byte_position >= mhlt_pkg::POS_W'(mhlt_pkg::MAX_HEADER_BYTES)) begin
        emit      = 1'b1;
        emit_kind = mhlt_pkg::KIND_OVERFLOW;
      end else begin
        skipping_leading_next = 1'b0;
        byte_position_next    = byte_position + 1'b1;
        if (tok.is_lf) begin
          newline_run_next = run_inc;
          if (run_inc >= 2'd2) begin
            emit      = 1'b1;
            emit_kind = mhlt_pkg::KIND_END;
          end else begin
            if (on_first_line) begin
              emit           = 1'b1;
              emit_kind      = mhlt_pkg::KIND_START;
              emit_has_value = name_nonempty;
              emit_vf        = name_first;
              emit_vl        = name_last;
            end else if (colon_seen) begin
              emit           = 1'b1;
              emit_kind      = mhlt_pkg::KIND_PAIR;
              emit_has_name  = name_nonempty;
              emit_has_value = value_nonempty;
            end else if (name_nonempty) begin
              emit           = 1'b1;
              emit_kind      = mhlt_pkg::KIND_NAMELESS;
              emit_has_value = 1'b1;
              emit_vf        = name_first;
              emit_vl        = name_last;
            end
            on_first_line_next  = 1'b0;
            colon_seen_next     = 1'b0;
            name_first_next     = '0;
            name_last_next      = '0;
            name_nonempty_next  = 1'b0;
            value_first_next    = '0;
            value_last_next     = '0;
            value_nonempty_next = 1'b0;
          end
        end else begin
          if (!tok.is_cr) begin
            newline_run_next = 2'd0;
          end
          if (tok.is_colon && !on_first_line && !colon_seen) begin
            colon_seen_next = 1'b1;
          end else if (!tok.is_space) begin
            if (colon_seen) begin
              if (!value_nonempty) begin
                value_first_next    = off;
                value_nonempty_next = 1'b1;
              end
              value_last_next = off;
            end else begin
              if (!name_nonempty) begin
                name_first_next    = off;
                name_nonempty_next = 1'b1;
              end
              name_last_next = off;
            end
          end
        end
      end

      // End of block, truncation and overflow all re-arm the tracker.
      if (emit && (emit_kind == mhlt_pkg::KIND_END || emit_kind == mhlt_pkg::KIND_TRUNC ||
                   emit_kind == mhlt_pkg::KIND_OVERFLOW)) begin
        byte_position_next    = '0;
        newline_run_next      = 2'd0;
        skipping_leading_next = 1'b1;
        on_first_line_next    = 1'b1;
        colon_seen_next       = 1'b0;
        name_first_next       = '0;
        name_last_next        = '0;
        name_nonempty_next    = 1'b0;
        value_first_next      = '0;
        value_last_next       = '0;
        value_nonempty_next   = 1'b0;
      end
    end
  end

  // Tracking state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      newline_run      <= 2'd0;
      skipping_leading <= 1'b1;
      on_first_line    <= 1'b1;
      colon_seen       <= 1'b0;
      name_first       <= '0;
      name_last        <= '0;
      name_nonempty    <= 1'b0;
      value_first      <= '0;
      value_last       <= '0;
      value_nonempty   <= 1'b0;
    end else begin
      byte_position    <= byte_position_next;
      newline_run      <= newline_run_next;
      skipping_leading <= skipping_leading_next;
      on_first_line    <= on_first_line_next;
      colon_seen       <= colon_seen_next;
      name_first       <= name_first_next;
      name_last        <= name_last_next;
      name_nonempty    <= name_nonempty_next;
      value_first      <= value_first_next;
      value_last       <= value_last_next;
      value_nonempty   <= value_nonempty_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload; unused spans read as zero.
  always_ff @(posedge clk) begin
    if (emit) begin
      res_kind <= emit_kind;
      if (emit_has_name) begin
        res_name_start  <= mhlt_pkg::START_W'(name_first);
        res_name_length <= mhlt_pkg::LEN_W'(name_last) - mhlt_pkg::LEN_W'(name_first)
                           + mhlt_pkg::LEN_W'(1);
      end else begin
        res_name_start  <= '0;
        res_name_length <= '0;
      end
      if (emit_has_value) begin
        res_value_start  <= mhlt_pkg::START_W'(emit_vf);
        res_value_length <= mhlt_pkg::LEN_W'(emit_vl) - mhlt_pkg::LEN_W'(emit_vf)
                            + mhlt_pkg::LEN_W'(1);
      end else begin
        res_value_start  <= '0;
        res_value_length <= '0;
      end
    end
  end

endmodule

`default_nettype wire
